@@ rtl/scds_pkg.sv @@
// Package for the serial clock divisor search block.
// Shared constants, register indexes and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package scds_pkg;

   // Field widths
   localparam int unsigned RATE_W   = 32;
   localparam int unsigned PRESC_W  = 8;
   localparam int unsigned POST_W   = 8;
   localparam int unsigned ACH_W    = 31;
   localparam int unsigned PROD_W   = 40;   // rate * prescale
   localparam int unsigned DEN_W    = 16;   // prescale * (1 + post)
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned CSR_IDX_W = 1;

   // Iterative divider: one quotient bit per cycle
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // Configuration defaults
   localparam logic [RATE_W-1:0]  CLK_HZ_RESET       = 32'd150000000;
   localparam logic [PRESC_W-1:0] MIN_PRESCALE_RESET = 8'd2;
   localparam int unsigned        MAX_PRESCALE_DEFAULT = 254;
   localparam logic [POST_W-1:0]  POST_MAX           = 8'd255;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PERIPHERAL_CLOCK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PRESCALE     = 1'b1;

   // Controller -> datapath commands
   typedef struct packed {
      logic init;           // latch request, set first prescale, clear best
      logic mul_prod;       // divisor = rate * prescale
      logic div_q;          // start clk-1 / prod
      logic post_sat;       // post = 255 (zero product)
      logic post_clear;     // post = 0 (zero clock)
      logic take_post;      // post = min(quotient, 255)
      logic mul_den;        // divisor = prescale * (1 + post)
      logic div_a;          // start clk / den
      logic take_achieved;  // achieved rate = quotient
      logic eval;           // compare with best, step prescale
      logic deliver;        // present the result
   } cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic prod_zero;
      logic clk_zero;
      logic div_done;
      logic exact;          // candidate taken with zero error
      logic last_p;         // candidate is the largest prescale
   } status_type;

endpackage

`default_nettype wire

@@ rtl/spi_clock_divisor_search_top.sv @@
// Serial clock divisor search: top level.
// Depends on scds_pkg, scds_ctrl, scds_dpath (which holds scds_div).
//
// Usage:
//  - Request: drive req_target_rate_hz and raise start while busy is low; the
//    transfer happens at that edge. busy stays high until the result is out.
//  - Result: rsp_valid is high for exactly one cycle with rsp_prescale_value,
//    rsp_post_divider, rsp_achieved_rate_hz and rsp_rate_error_hz. The receiver
//    cannot stall; it must take the result in that cycle.
//  - Configuration: csr_write_enable with csr_index (0 peripheral clock in Hz,
//    1 minimum prescale) and csr_write_data, only while busy is low.
//  - Timing: each even prescale candidate makes two passes through a shared
//    32-step restoring divider (ceiling post-divider, then achieved rate) plus
//    setup/compare states; the ceiling division is skipped when the product
//    or the clock is zero. With the defaults a full sweep covers all 127
//    candidates, and the next request can transfer in the cycle after the
//    result strobe. The sweep ends early at the first exact match; one
//    request at a time.
//  - Reset (synchronous, active high): controller idles, peripheral clock
//    returns to 150 MHz and the minimum prescale to 2.
`default_nettype none

module spi_clock_divisor_search_top #(
   parameter int unsigned MAX_PRESCALE = scds_pkg::MAX_PRESCALE_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [scds_pkg::RATE_W-1:0]     req_target_rate_hz,
   // Result channel
   output logic                                 rsp_valid,
   output logic [scds_pkg::PRESC_W-1:0]         rsp_prescale_value,
   output logic [scds_pkg::POST_W-1:0]          rsp_post_divider,
   output logic [scds_pkg::ACH_W-1:0]           rsp_achieved_rate_hz,
   output logic [scds_pkg::RATE_W-1:0]          rsp_rate_error_hz,
   // Configuration port
   input  wire logic                            csr_write_enable,
   input  wire logic [scds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [scds_pkg::CSR_W-1:0]      csr_write_data
);

   scds_pkg::cmd_type    cmd;
   scds_pkg::status_type status;

   // Sequencer
   scds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and storage
   scds_dpath #(
      .MAX_PRESCALE (MAX_PRESCALE)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .target_rate_hz   (req_target_rate_hz),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .prescale_value   (rsp_prescale_value),
      .post_divider     (rsp_post_divider),
      .achieved_rate_hz (rsp_achieved_rate_hz),
      .rate_error_hz    (rsp_rate_error_hz)
   );

endmodule

`default_nettype wire

@@ rtl/scds_div.sv @@
// Restoring divider, one quotient bit per cycle: 32-bit dividend, 40-bit divisor.
// Depends on scds_pkg.
`default_nettype none

module scds_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [scds_pkg::RATE_W-1:0]   dividend,
   input  wire logic [scds_pkg::PROD_W-1:0]   divisor,
   output logic                               done,
   output logic [scds_pkg::RATE_W-1:0]        quotient
);

   localparam int unsigned RW = scds_pkg::PROD_W;
   localparam int unsigned DW = scds_pkg::RATE_W;
   localparam int unsigned CW = scds_pkg::DIV_CNT_W;

   logic [RW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [RW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW:0]   trial;
   logic          ge;

   // Shift-subtract step
   assign trial = {rem_ff, dvd_ff[DW-1]};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CW'(scds_pkg::DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? RW'(trial - {1'b0, dsr_ff}) : trial[RW-1:0];
         dvd_in = {dvd_ff[DW-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operands
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

@@ rtl/scds_dpath.sv @@
// Datapath: configuration registers, candidate arithmetic, best-pair tracking, result registers.
// Depends on scds_pkg and scds_div.
`default_nettype none

module scds_dpath #(
   parameter int unsigned MAX_PRESCALE = scds_pkg::MAX_PRESCALE_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire scds_pkg::cmd_type               cmd,
   output scds_pkg::status_type                 status,
   input  wire logic [scds_pkg::RATE_W-1:0]     target_rate_hz,
   input  wire logic                            csr_write_enable,
   input  wire logic [scds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [scds_pkg::CSR_W-1:0]      csr_write_data,
   output logic [scds_pkg::PRESC_W-1:0]         prescale_value,
   output logic [scds_pkg::POST_W-1:0]          post_divider,
   output logic [scds_pkg::ACH_W-1:0]           achieved_rate_hz,
   output logic [scds_pkg::RATE_W-1:0]          rate_error_hz
);

   localparam int unsigned RW = scds_pkg::RATE_W;
   localparam int unsigned PW = scds_pkg::PRESC_W;
   localparam int unsigned OW = scds_pkg::POST_W;
   localparam int unsigned AW = scds_pkg::ACH_W;
   localparam int unsigned XW = scds_pkg::PROD_W;
   localparam int unsigned NW = scds_pkg::DEN_W;
   localparam int unsigned TOP_EVEN = MAX_PRESCALE & 32'hFFFF_FFFE;
   localparam logic [PW-1:0] TOP_P = PW'((TOP_EVEN < 2) ? 2 : TOP_EVEN);

   logic [RW-1:0] clk_ff;
   logic [PW-1:0] minp_ff;
   logic [RW-1:0] rate_ff;
   logic [PW-1:0] p_ff, p_in;
   logic [OW-1:0] post_ff, post_in;
   logic [XW-1:0] prod_ff;
   logic [NW-1:0] den_ff;
   logic [AW-1:0] ach_ff;
   logic          have_ff;
   logic [PW-1:0] best_p_ff;
   logic [OW-1:0] best_post_ff;
   logic [AW-1:0] best_ach_ff;
   logic [RW-1:0] best_err_ff;

   logic [PW-1:0] first_p;
   logic [PW-1:0] minp_even;
   logic [RW-1:0] err;
   logic [RW-1:0] ach_ext;
   logic          take;
   logic          div_start;
   logic [RW-1:0] div_dividend;
   logic [XW-1:0] div_divisor;
   logic          div_done;
   logic [RW-1:0] div_quo;
   logic [NW:0]   den_full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff  <= scds_pkg::CLK_HZ_RESET;
         minp_ff <= scds_pkg::MIN_PRESCALE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            scds_pkg::CSR_PERIPHERAL_CLOCK: clk_ff  <= csr_write_data;
            scds_pkg::CSR_MIN_PRESCALE:     minp_ff <= csr_write_data[PW-1:0];
            default: ;
         endcase
      end
   end

   // First prescale: even, at least two, at most the top
   always_comb begin
      minp_even = {minp_ff[PW-1:1], 1'b0};
      if (minp_even < PW'(2)) begin
         first_p = PW'(2);
      end else if (minp_even > TOP_P) begin
         first_p = TOP_P;
      end else begin
         first_p = minp_even;
      end
   end

   // Shared divider
   assign div_start    = cmd.div_q | cmd.div_a;
   assign div_dividend = cmd.div_q ? (clk_ff - RW'(1)) : clk_ff;
   assign div_divisor  = cmd.div_q ? prod_ff : XW'(den_ff);

   scds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Candidate error and best compare
   assign ach_ext = RW'(ach_ff);
   assign err  = (ach_ext > rate_ff) ? (ach_ext - rate_ff) : (rate_ff - ach_ext);
   assign take = !have_ff || (err < best_err_ff);
   assign den_full = (NW+1)'(p_ff) * ((NW+1)'(post_ff) + (NW+1)'(1));

   // Post-divider select
   always_comb begin
      post_in = post_ff;
      if (cmd.post_sat) begin
         post_in = scds_pkg::POST_MAX;
      end else if (cmd.post_clear) begin
         post_in = '0;
      end else if (cmd.take_post) begin
         post_in = (div_quo > RW'(scds_pkg::POST_MAX)) ? scds_pkg::POST_MAX : div_quo[OW-1:0];
      end
   end

   assign p_in = cmd.init ? first_p : (cmd.eval ? (p_ff + PW'(2)) : p_ff);

   // Working registers
   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      post_ff <= post_in;
      if (cmd.init) begin
         rate_ff <= target_rate_hz;
      end
      if (cmd.mul_prod) begin
         prod_ff <= XW'(rate_ff) * XW'(p_ff);
      end
      if (cmd.mul_den) begin
         den_ff <= den_full[NW-1:0];
      end
      if (cmd.take_achieved) begin
         ach_ff <= div_quo[AW-1:0];
      end
   end

   // Best pair so far
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (cmd.init) begin
         have_ff <= 1'b0;
      end else if (cmd.eval) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval && take) begin
         best_p_ff    <= p_ff;
         best_post_ff <= post_ff;
         best_ach_ff  <= ach_ff;
         best_err_ff  <= err;
      end
   end

   // Status
   assign status.prod_zero = (prod_ff == '0);
   assign status.clk_zero  = (clk_ff == '0);
   assign status.div_done  = div_done;
   assign status.exact     = take && (err == '0);
   assign status.last_p    = (p_ff == TOP_P);

   // Result fields hold the best pair while the strobe is up
   assign prescale_value   = best_p_ff;
   assign post_divider     = best_post_ff;
   assign achieved_rate_hz = best_ach_ff;
   assign rate_error_hz    = best_err_ff;

endmodule

`default_nettype wire

@@ rtl/scds_ctrl.sv @@
// Controller state machine: sequences the candidate loop and drives datapath commands.
// Depends on scds_pkg.
`default_nettype none

module scds_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output logic                       rsp_valid,
   output scds_pkg::cmd_type          cmd,
   input  wire scds_pkg::status_type  status
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_PROD   = 9'b000000010,
      ST_QSTART = 9'b000000100,
      ST_QWAIT  = 9'b000001000,
      ST_DEN    = 9'b000010000,
      ST_ASTART = 9'b000100000,
      ST_AWAIT  = 9'b001000000,
      ST_EVAL   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.init = 1'b1;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.mul_prod = 1'b1;
            state_in     = ST_QSTART;
         end
         ST_QSTART: begin
            priority if (status.prod_zero) begin
               cmd.post_sat = 1'b1;
               state_in     = ST_DEN;
            end else if (status.clk_zero) begin
               cmd.post_clear = 1'b1;
               state_in       = ST_DEN;
            end else begin
               cmd.div_q = 1'b1;
               state_in  = ST_QWAIT;
            end
         end
         ST_QWAIT: begin
            if (status.div_done) begin
               cmd.take_post = 1'b1;
               state_in      = ST_DEN;
            end
         end
         ST_DEN: begin
            cmd.mul_den = 1'b1;
            state_in    = ST_ASTART;
         end
         ST_ASTART: begin
            cmd.div_a = 1'b1;
            state_in  = ST_AWAIT;
         end
         ST_AWAIT: begin
            if (status.div_done) begin
               cmd.take_achieved = 1'b1;
               state_in          = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = (status.exact || status.last_p) ? ST_DONE : ST_PROD;
         end
         ST_DONE: begin
            cmd.deliver = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = cmd.deliver;

endmodule

`default_nettype wire

@@ tb/tb_spi_clock_divisor_search_top.sv @@
// Self-checking testbench for spi_clock_divisor_search_top.
// Drives rate requests and divider configuration, predicts each chosen prescale/post pair.
// Depends on scds_pkg and the spi_clock_divisor_search_top RTL.

module tb_spi_clock_divisor_search_top;
   import scds_pkg::*;

   localparam int unsigned LAST_PRESCALE = MAX_PRESCALE_DEFAULT - (MAX_PRESCALE_DEFAULT % 2);
   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned ITEMS_PER_PHASE = 10;
   localparam int unsigned SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [PRESC_W-1:0] prescale_value;
      logic [POST_W-1:0]  post_divider;
      logic [ACH_W-1:0]   achieved_rate_hz;
      logic [RATE_W-1:0]  rate_error_hz;
   } divisor_choice_t;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [RATE_W-1:0]    req_target_rate_hz;
   logic                 rsp_valid;
   logic [PRESC_W-1:0]   rsp_prescale_value;
   logic [POST_W-1:0]    rsp_post_divider;
   logic [ACH_W-1:0]     rsp_achieved_rate_hz;
   logic [RATE_W-1:0]    rsp_rate_error_hz;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;

   // Shadow copy of the divider configuration
   logic [RATE_W-1:0]    shadow_clk_hz;
   logic [PRESC_W-1:0]   shadow_min_prescale;

   divisor_choice_t      expected_choices[$];
   int unsigned          mismatch_count;

   spi_clock_divisor_search_top u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_target_rate_hz   (req_target_rate_hz),
      .rsp_valid            (rsp_valid),
      .rsp_prescale_value   (rsp_prescale_value),
      .rsp_post_divider     (rsp_post_divider),
      .rsp_achieved_rate_hz (rsp_achieved_rate_hz),
      .rsp_rate_error_hz    (rsp_rate_error_hz),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   // Clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Even prescale the sweep starts from under the current configuration
   function automatic int unsigned first_even_prescale();
      int unsigned first_p;
      first_p = shadow_min_prescale & 8'hFE;
      if (first_p < 2) first_p = 2;
      if (first_p > LAST_PRESCALE) first_p = LAST_PRESCALE;
      return first_p;
   endfunction

   // Sweep the even prescales and keep the pair nearest the requested rate
   function automatic divisor_choice_t search_divisor(input logic [RATE_W-1:0] rate);
      divisor_choice_t best;
      logic [63:0]     clk64, rate64, p64, prod, quot, post, achieved, err, best_err;
      bit              have;
      int unsigned     p;
      clk64    = shadow_clk_hz;
      rate64   = rate;
      have     = 1'b0;
      best     = '0;
      best_err = '0;
      for (p = first_even_prescale(); p <= LAST_PRESCALE; p += 2) begin
         p64  = p;
         prod = rate64 * p64;
         if (prod == 0) begin
            post = 64'd255;
         end else begin
            quot = (clk64 + prod - 64'd1) / prod;
            if (quot == 0) post = 64'd0;
            else if (quot - 64'd1 > 64'd255) post = 64'd255;
            else post = quot - 64'd1;
         end
         achieved = clk64 / (p64 * (post + 64'd1));
         err = (achieved > rate64) ? achieved - rate64 : rate64 - achieved;
         if (!have || err < best_err) begin
            have                  = 1'b1;
            best_err              = err;
            best.prescale_value   = p[PRESC_W-1:0];
            best.post_divider     = post[POST_W-1:0];
            best.achieved_rate_hz = achieved[ACH_W-1:0];
            best.rate_error_hz    = err[RATE_W-1:0];
            if (err == 0) break;
         end
      end
      return best;
   endfunction

   // Idle length before a request: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return 0;
      if (roll < 8) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // Random rate; half of them hit an achievable pair so the sweep can stop early
   function automatic logic [RATE_W-1:0] pick_rate();
      int unsigned first_p, p, post;
      first_p = first_even_prescale();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            p    = first_p + 2 * $urandom_range(0, (LAST_PRESCALE - first_p) / 2);
            post = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
            return shadow_clk_hz / (p * (post + 1));
         end
         5, 6:    return $urandom;
         7:       return $urandom_range(0, 1000);
         8:       return shadow_clk_hz / $urandom_range(2, 65024) + $urandom_range(0, 2);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // Send one rate request; the transfer is the edge where start is high and busy low
   task automatic request_rate(input logic [RATE_W-1:0] rate);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         start <= 1'b0;
         do @(posedge clock); while (busy);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start              <= 1'b1;
      req_target_rate_hz <= rate;
      do @(posedge clock); while (busy);
      expected_choices.push_back(search_divisor(rate));
   endtask

   // Drop start and wait until every search has reported and the block is idle
   task automatic wait_search_idle();
      @(negedge clock);
      start <= 1'b0;
      while (expected_choices.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_PERIPHERAL_CLOCK) shadow_clk_hz = data;
      else shadow_min_prescale = data[PRESC_W-1:0];
   endtask

   // Reset configuration: exact hits, zero and tiny rates, the widest rates
   task automatic test_reset_defaults();
      request_rate(32'd75_000_000);
      request_rate(32'd1_000_000);
      request_rate(32'd0);
      request_rate(32'd1);
      request_rate(32'hFFFF_FFFF);
      request_rate(32'h8000_0000);
      wait_search_idle();
   endtask

   // Zero, unit and all-ones peripheral clock
   task automatic test_clock_extremes();
      write_csr(CSR_PERIPHERAL_CLOCK, 32'd0);
      request_rate(32'hFFFF_FFFF);   // every candidate errs by all ones
      request_rate(32'd12345);
      wait_search_idle();
      write_csr(CSR_PERIPHERAL_CLOCK, 32'd1);
      request_rate(32'd1);
      request_rate(32'd0);
      wait_search_idle();
      write_csr(CSR_PERIPHERAL_CLOCK, 32'hFFFF_FFFF);
      request_rate(32'hFFFF_FFFF);
      request_rate(32'd1);
      request_rate(32'h7FFF_FFFF);
      wait_search_idle();
   endtask

   // Minimum prescale below two, odd, at the top and past the top
   task automatic test_prescale_floor();
      logic [PRESC_W-1:0] floors[5];
      floors = '{8'd0, 8'd1, 8'd3, 8'd254, 8'd255};
      write_csr(CSR_PERIPHERAL_CLOCK, CLK_HZ_RESET);
      foreach (floors[i]) begin
         write_csr(CSR_MIN_PRESCALE, {24'hA5A5A5, floors[i]});
         request_rate(32'd1_234_567);
         wait_search_idle();
      end
   endtask

   // Random configurations, each followed by a burst of random requests
   task automatic test_random_traffic();
      logic [CSR_W-1:0] clk_hz;
      logic [CSR_W-1:0] min_word;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 7))
            0:       clk_hz = $urandom_range(0, 3);
            1:       clk_hz = 32'hFFFF_FFFF;
            2, 3:    clk_hz = $urandom;
            default: clk_hz = $urandom_range(1_000_000, 500_000_000);
         endcase
         // high floors keep most sweeps short
         min_word = $urandom & 32'hFFFF_FF00;
         min_word[PRESC_W-1:0] = ($urandom_range(0, 9) < 6) ? $urandom_range(160, 255)
                                                            : $urandom_range(0, 255);
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_PERIPHERAL_CLOCK, clk_hz);
            write_csr(CSR_MIN_PRESCALE, min_word);
         end else begin
            write_csr(CSR_MIN_PRESCALE, min_word);
            write_csr(CSR_PERIPHERAL_CLOCK, clk_hz);
         end
         repeat (ITEMS_PER_PHASE) request_rate(pick_rate());
         wait_search_idle();
      end
   endtask

   // Result checker: each strobe is compared with the oldest prediction
   always @(posedge clock) begin
      divisor_choice_t want;
      if (!reset && rsp_valid) begin
         if (expected_choices.size() == 0) begin
            $error("unexpected result transfer: prescale %0d post %0d",
                   rsp_prescale_value, rsp_post_divider);
            mismatch_count++;
         end else begin
            want = expected_choices.pop_front();
            if (rsp_prescale_value !== want.prescale_value) begin
               $error("rsp_prescale_value: expected %0d, got %0d",
                      want.prescale_value, rsp_prescale_value);
               mismatch_count++;
            end
            if (rsp_post_divider !== want.post_divider) begin
               $error("rsp_post_divider: expected %0d, got %0d",
                      want.post_divider, rsp_post_divider);
               mismatch_count++;
            end
            if (rsp_achieved_rate_hz !== want.achieved_rate_hz) begin
               $error("rsp_achieved_rate_hz: expected %0d, got %0d",
                      want.achieved_rate_hz, rsp_achieved_rate_hz);
               mismatch_count++;
            end
            if (rsp_rate_error_hz !== want.rate_error_hz) begin
               $error("rsp_rate_error_hz: expected %0d, got %0d",
                      want.rate_error_hz, rsp_rate_error_hz);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence
   initial begin
      reset               = 1'b1;
      start               = 1'b0;
      req_target_rate_hz  = '0;
      csr_write_enable    = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      shadow_clk_hz       = CLK_HZ_RESET;
      shadow_min_prescale = MIN_PRESCALE_RESET;
      mismatch_count      = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_clock_extremes();
      test_prescale_floor();
      test_random_traffic();

      wait_search_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond a run where every request sweeps all prescales
   initial begin
      #80_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
